FILE: src/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants
// Widths, store depth and the per-cell control struct for the sort/search
// block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sts_pkg;
   localparam int DEPTH   = 64;
   localparam int VAL_W   = 31;
   localparam int IDX_W   = 6;
   localparam int CNT_W   = 7;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic KIND_ELEM   = 1'b0;
   localparam logic KIND_ANSWER = 1'b1;

   // control broadcast to every cell
   typedef struct packed {
      logic             rotate;   // every cell takes its right neighbor
      logic             sort;     // odd-even compare and exchange
      logic             phase;    // which pairing is active this pass
      logic             load;     // write one cell
      logic [CNT_W-1:0] load_idx;
      logic [CNT_W-1:0] count;    // cells below count take part in sorting
   } cell_ctrl_type;
endpackage
`default_nettype wire

FILE: src/sts_cell.sv
// ----------------------------------------------------------------------------
// sts_cell: one storage cell of the element chain
// Holds one element; loads, rotates toward the head, or compare-exchanges
// with a neighbor in an odd-even transposition pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sts_cell (
   input  wire logic                      clock,
   input  wire sts_pkg::cell_ctrl_type    ctrl,
   input  wire logic [sts_pkg::CNT_W-1:0] idx,
   input  wire logic [sts_pkg::VAL_W-1:0] load_val,
   input  wire logic [sts_pkg::VAL_W-1:0] left_val,
   input  wire logic [sts_pkg::VAL_W-1:0] right_val,
   output logic      [sts_pkg::VAL_W-1:0] val
);
   logic [sts_pkg::VAL_W-1:0] val_ff;
   logic [sts_pkg::VAL_W-1:0] val_in;
   logic                      pair_right;
   logic                      pair_left;

   // pairing for this pass: strictly greater only, so equal values keep order
   assign pair_right = (idx[0] == ctrl.phase) &&
                       ((idx + sts_pkg::CNT_W'(1)) < ctrl.count);
   assign pair_left  = (idx[0] != ctrl.phase) && (idx != '0) && (idx < ctrl.count);

   // next value
   always_comb begin
      val_in = val_ff;
      if (ctrl.load && ctrl.load_idx == idx) begin
         val_in = load_val;
      end else if (ctrl.rotate) begin
         val_in = right_val;
      end else if (ctrl.sort) begin
         if (pair_right && val_ff > right_val) begin
            val_in = right_val;
         end else if (pair_left && left_val > val_ff) begin
            val_in = left_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;
endmodule
`default_nettype wire

FILE: src/sort_then_binary_search.sv
// ----------------------------------------------------------------------------
// sort_then_binary_search: load, stable sort and binary search
// Elements sit in a ring of cells; sorting is odd-even transposition in
// place, reads happen at the head cell while the ring rotates.
// ----------------------------------------------------------------------------
// A load writes the next free cell while the store has room; a load marked
// last then sorts the run in place and streams all 64 ring positions past
// the head, one result per stored element. A search rotates the ring
// forward to each probed index and back to the head; a probe below the
// current one costs a full turn of the ring, since the single-ported head
// of the cell ring is the only place where a stored value can be read.
// Results appear for one cycle on rsp_valid and cannot be stalled; start is
// taken only while busy is low.
`timescale 1ns / 1ps
`default_nettype none
module sort_then_binary_search (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic                      req_opcode,
   input  wire logic [sts_pkg::VAL_W-1:0] req_item_value,
   input  wire logic                      req_load_last,
   output logic                           rsp_valid,
   output logic                           rsp_result_kind,
   output logic      [sts_pkg::VAL_W-1:0] rsp_out_value,
   output logic      [sts_pkg::IDX_W-1:0] rsp_out_index,
   output logic                           rsp_found,
   output logic                           rsp_run_last
);
   localparam logic [sts_pkg::CNT_W-1:0] DEPTH_C = sts_pkg::CNT_W'(sts_pkg::DEPTH);
   localparam logic [sts_pkg::IDX_W-1:0] HEAD_MAX = sts_pkg::IDX_W'(sts_pkg::DEPTH - 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SORT = 5'b00010,
      S_EMIT = 5'b00100,
      S_SEEK = 5'b01000,
      S_HOME = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic [sts_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      sorted_ff, sorted_in;
   logic [sts_pkg::IDX_W-1:0] head_ff, head_in;
   logic [sts_pkg::CNT_W-1:0] pass_ff, pass_in;
   logic signed [7:0]         lo_ff, lo_in, hi_ff, hi_in;
   logic [sts_pkg::VAL_W-1:0] key_ff, key_in;
   logic                      valid_ff, valid_in;
   logic                      kind_ff, kind_in;
   logic [sts_pkg::VAL_W-1:0] oval_ff, oval_in;
   logic [sts_pkg::IDX_W-1:0] oidx_ff, oidx_in;
   logic                      found_ff, found_in;
   logic                      last_ff, last_in;

   sts_pkg::cell_ctrl_type    ctrl;
   logic [sts_pkg::VAL_W-1:0] q [sts_pkg::DEPTH];
   logic [sts_pkg::CNT_W-1:0] base;
   logic signed [7:0]         mid_sum;
   logic [sts_pkg::IDX_W-1:0] mid;
   logic                      accept;

   assign accept  = start && (state_ff == S_IDLE);
   assign base    = sorted_ff ? '0 : count_ff;
   assign mid_sum = lo_ff + hi_ff;
   assign mid     = mid_sum[sts_pkg::IDX_W:1];

   // sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      sorted_in = sorted_ff;
      head_in   = head_ff;
      pass_in   = pass_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      key_in    = key_ff;
      valid_in  = 1'b0;
      kind_in   = kind_ff;
      oval_in   = oval_ff;
      oidx_in   = oidx_ff;
      found_in  = found_ff;
      last_in   = last_ff;
      ctrl      = '0;
      ctrl.count    = count_ff;
      ctrl.phase    = pass_ff[0];
      ctrl.load_idx = base;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_opcode == sts_pkg::OP_LOAD) begin
               sorted_in = 1'b0;
               count_in  = base;
               if (base < DEPTH_C) begin
                  ctrl.load = 1'b1;
                  count_in  = base + sts_pkg::CNT_W'(1);
               end
               if (req_load_last) begin
                  sorted_in = 1'b1;
                  pass_in   = '0;
                  state_in  = S_SORT;
               end
            end else if (accept) begin
               key_in   = req_item_value;
               lo_in    = '0;
               hi_in    = $signed({1'b0, count_ff}) - 8'sd1;
               state_in = S_SEEK;
            end
         end
         S_SORT: begin
            if (pass_ff >= count_ff) begin
               state_in = S_EMIT;
            end else begin
               ctrl.sort = 1'b1;
               pass_in   = pass_ff + sts_pkg::CNT_W'(1);
            end
         end
         S_EMIT: begin
            // stream the ring past the head, reporting stored positions
            ctrl.rotate = 1'b1;
            head_in     = (head_ff == HEAD_MAX) ? '0 : head_ff + sts_pkg::IDX_W'(1);
            if ({1'b0, head_ff} < count_ff) begin
               valid_in = 1'b1;
               kind_in  = sts_pkg::KIND_ELEM;
               oval_in  = q[0];
               oidx_in  = head_ff;
               found_in = 1'b0;
               last_in  = ({1'b0, head_ff} + sts_pkg::CNT_W'(1)) == count_ff;
            end
            if (head_ff == HEAD_MAX) begin
               state_in = S_IDLE;
            end
         end
         S_SEEK: begin
            if (lo_ff > hi_ff) begin
               valid_in = 1'b1;
               kind_in  = sts_pkg::KIND_ANSWER;
               oval_in  = key_ff;
               oidx_in  = '0;
               found_in = 1'b0;
               last_in  = 1'b1;
               state_in = S_HOME;
            end else if (head_ff == mid) begin
               if (q[0] == key_ff) begin
                  valid_in = 1'b1;
                  kind_in  = sts_pkg::KIND_ANSWER;
                  oval_in  = key_ff;
                  oidx_in  = mid;
                  found_in = 1'b1;
                  last_in  = 1'b1;
                  state_in = S_HOME;
               end else if (key_ff < q[0]) begin
                  hi_in = $signed({2'b00, mid}) - 8'sd1;
               end else begin
                  lo_in = $signed({2'b00, mid}) + 8'sd1;
               end
            end else begin
               ctrl.rotate = 1'b1;
               head_in = (head_ff == HEAD_MAX) ? '0 : head_ff + sts_pkg::IDX_W'(1);
            end
         end
         S_HOME: begin
            if (head_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               ctrl.rotate = 1'b1;
               head_in = (head_ff == HEAD_MAX) ? '0 : head_ff + sts_pkg::IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         sorted_ff <= 1'b1;
         head_ff   <= '0;
         pass_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         sorted_ff <= sorted_in;
         head_ff   <= head_in;
         pass_ff   <= pass_in;
         valid_ff  <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      key_ff   <= key_in;
      kind_ff  <= kind_in;
      oval_ff  <= oval_in;
      oidx_ff  <= oidx_in;
      found_ff <= found_in;
      last_ff  <= last_in;
   end

   // ring of cells
   for (genvar g = 0; g < sts_pkg::DEPTH; g++) begin : g_cell
      sts_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .idx       (sts_pkg::CNT_W'(g)),
         .load_val  (req_item_value),
         .left_val  (q[(g + sts_pkg::DEPTH - 1) % sts_pkg::DEPTH]),
         .right_val (q[(g + 1) % sts_pkg::DEPTH]),
         .val       (q[g])
      );
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_out_value   = oval_ff;
   assign rsp_out_index   = oidx_ff;
   assign rsp_found       = found_ff;
   assign rsp_run_last    = last_ff;

   // ring is back in logical order whenever idle
   a_home_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (head_ff == '0))
      else $error("ring not at head while idle");
   // no result while sorting
   a_sort_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SORT) |-> !rsp_valid)
      else $error("result during sort");
   // element count stays within the store
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("element count overflow");
endmodule
`default_nettype wire

FILE: tb/sort_then_binary_search_tb.sv
// ----------------------------------------------------------------------------
// sort_then_binary_search_tb: self-checking bench for the sort/search block
// Loads runs of values, sorts them and searches them, predicts every answer
// in the bench and checks each response transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sort_then_binary_search_tb;
   typedef struct {
      logic                      opcode;
      logic [sts_pkg::VAL_W-1:0] value;
      logic                      last;
   } cmd_type;

   typedef struct {
      logic                      kind;
      logic [sts_pkg::VAL_W-1:0] value;
      logic [sts_pkg::IDX_W-1:0] index;
      logic                      found;
      logic                      run_last;
   } answer_type;

   localparam int LIMIT_CYCLES = 400000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_opcode = sts_pkg::OP_LOAD;
   logic [sts_pkg::VAL_W-1:0] req_item_value = '0;
   logic                      req_load_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_result_kind;
   logic [sts_pkg::VAL_W-1:0] rsp_out_value;
   logic [sts_pkg::IDX_W-1:0] rsp_out_index;
   logic                      rsp_found;
   logic                      rsp_run_last;

   // pending commands and predicted answers
   cmd_type    cmd_queue[$];
   answer_type answer_queue[$];

   // predictor state
   logic [sts_pkg::VAL_W-1:0] shadow_store[sts_pkg::DEPTH];
   logic [sts_pkg::CNT_W-1:0] shadow_count = '0;
   logic                      shadow_sorted = 1'b1;

   int issued = 0;
   int accepted = 0;
   int gap_left = 0;
   int mismatches = 0;
   int responses = 0;
   int sorts_seen = 0;
   int searches_seen = 0;
   int cycles = 0;
   bit burst_mode = 1'b0;

   // values loaded by the generator, reused as search targets
   logic [sts_pkg::VAL_W-1:0] known_vals[$];

   sort_then_binary_search u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_item_value(req_item_value),
      .req_load_last(req_load_last), .rsp_valid(rsp_valid),
      .rsp_result_kind(rsp_result_kind), .rsp_out_value(rsp_out_value),
      .rsp_out_index(rsp_out_index), .rsp_found(rsp_found),
      .rsp_run_last(rsp_run_last)
   );

   always #5 clock = ~clock;

   // compute the answers one accepted transaction causes
   task automatic predict_answers(input logic op, input logic [sts_pkg::VAL_W-1:0] val,
                                  input logic last);
      answer_type                a;
      logic [sts_pkg::VAL_W-1:0] v;
      int                        lo, hi, mid, j;
      if (op == sts_pkg::OP_LOAD) begin
         if (shadow_sorted) begin
            shadow_count = '0;
            shadow_sorted = 1'b0;
         end
         if (shadow_count < sts_pkg::DEPTH) begin
            shadow_store[shadow_count] = val;
            shadow_count++;
         end
         if (last) begin
            // stable ascending insertion sort
            for (int i = 1; i < shadow_count; i++) begin
               v = shadow_store[i];
               j = i;
               while (j > 0 && shadow_store[j-1] > v) begin
                  shadow_store[j] = shadow_store[j-1];
                  j--;
               end
               shadow_store[j] = v;
            end
            shadow_sorted = 1'b1;
            sorts_seen++;
            for (int i = 0; i < shadow_count; i++) begin
               a.kind = sts_pkg::KIND_ELEM;
               a.value = shadow_store[i];
               a.index = i[sts_pkg::IDX_W-1:0];
               a.found = 1'b0;
               a.run_last = (i + 1 == shadow_count);
               answer_queue.push_back(a);
            end
         end
      end else begin
         a.kind = sts_pkg::KIND_ANSWER;
         a.value = val;
         a.index = '0;
         a.found = 1'b0;
         a.run_last = 1'b1;
         lo = 0;
         hi = int'(shadow_count) - 1;
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (val == shadow_store[mid]) begin
               a.index = mid[sts_pkg::IDX_W-1:0];
               a.found = 1'b1;
               break;
            end else if (val < shadow_store[mid]) hi = mid - 1;
            else lo = mid + 1;
         end
         searches_seen++;
         answer_queue.push_back(a);
      end
   endtask

   task automatic add_cmd(input logic op, input logic [sts_pkg::VAL_W-1:0] val,
                          input logic last);
      cmd_type c;
      c.opcode = op;
      c.value = val;
      c.last = last;
      cmd_queue.push_back(c);
      if (op == sts_pkg::OP_LOAD) known_vals.push_back(val);
   endtask

   function automatic logic [sts_pkg::VAL_W-1:0] rand_value();
      case ($urandom_range(0, 3))
         0: return sts_pkg::VAL_W'($urandom_range(0, 15));
         1: return {sts_pkg::VAL_W{1'b1}} - sts_pkg::VAL_W'($urandom_range(0, 15));
         default: return sts_pkg::VAL_W'($urandom);
      endcase
   endfunction

   // one load run of n values, sometimes with searches slipped in
   task automatic add_load_run(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            add_cmd(sts_pkg::OP_SEARCH, rand_value(), 1'($urandom_range(0, 1)));
         if (known_vals.size() > 0 && $urandom_range(0, 4) == 0)
            add_cmd(sts_pkg::OP_LOAD, known_vals[$urandom_range(0, known_vals.size() - 1)],
                    i == n - 1);
         else
            add_cmd(sts_pkg::OP_LOAD, rand_value(), i == n - 1);
      end
   endtask

   // count accepted transactions and predict
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && start && !busy) begin
         accepted <= accepted + 1;
         predict_answers(req_opcode, req_item_value, req_load_last);
      end
   end

   // driver: changes inputs on the falling edge
   always @(negedge clock) begin
      cmd_type c;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || accepted == issued) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
         end else if (cmd_queue.size() > 0) begin
            c = cmd_queue.pop_front();
            req_opcode <= c.opcode;
            req_item_value <= c.value;
            req_load_last <= c.last;
            start <= 1'b1;
            issued = issued + 1;
            if (issued % 25 == 0) burst_mode = ~burst_mode;
            gap_left = burst_mode ? 0 : $urandom_range(0, 12);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check each response transaction against the oldest prediction
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid) begin
         responses <= responses + 1;
         if (answer_queue.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
               $display("ERROR: unexpected response value=%0d index=%0d",
                        rsp_out_value, rsp_out_index);
         end else begin
            e = answer_queue.pop_front();
            if (rsp_result_kind !== e.kind || rsp_out_value !== e.value ||
                rsp_out_index !== e.index || rsp_found !== e.found ||
                rsp_run_last !== e.run_last) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display({"ERROR: kind %0d/%0d value %0d/%0d index %0d/%0d ",
                            "found %0d/%0d last %0d/%0d (expected/actual)"},
                           e.kind, rsp_result_kind, e.value, rsp_out_value,
                           e.index, rsp_out_index, e.found, rsp_found,
                           e.run_last, rsp_run_last);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > LIMIT_CYCLES) begin
         $display("ERROR: timeout after %0d cycles", cycles);
         $display("sort_then_binary_search test failed");
         $finish;
      end
   end

   initial begin
      int n;
      bit overflow_done;
      overflow_done = 1'b0;
      // directed: empty search, extremes, open-run search, duplicates
      add_cmd(sts_pkg::OP_SEARCH, '0, 1'b0);
      add_cmd(sts_pkg::OP_LOAD, '0, 1'b1);
      add_cmd(sts_pkg::OP_SEARCH, '0, 1'b1);
      add_cmd(sts_pkg::OP_SEARCH, sts_pkg::VAL_W'(1), 1'b0);
      add_cmd(sts_pkg::OP_LOAD, {sts_pkg::VAL_W{1'b1}}, 1'b0);
      add_cmd(sts_pkg::OP_LOAD, '0, 1'b0);
      add_cmd(sts_pkg::OP_SEARCH, '0, 1'b1);
      add_cmd(sts_pkg::OP_LOAD, sts_pkg::VAL_W'(31'h2aaaaaaa), 1'b0);
      add_cmd(sts_pkg::OP_LOAD, {sts_pkg::VAL_W{1'b1}}, 1'b0);
      add_cmd(sts_pkg::OP_LOAD, sts_pkg::VAL_W'(31'h55555555), 1'b1);
      add_cmd(sts_pkg::OP_SEARCH, {sts_pkg::VAL_W{1'b1}}, 1'b0);
      add_cmd(sts_pkg::OP_SEARCH, '0, 1'b0);
      add_cmd(sts_pkg::OP_SEARCH, sts_pkg::VAL_W'(31'h55555555), 1'b0);
      add_cmd(sts_pkg::OP_SEARCH, sts_pkg::VAL_W'(31'h12345678), 1'b1);
      add_cmd(sts_pkg::OP_LOAD, sts_pkg::VAL_W'(7), 1'b0);
      add_cmd(sts_pkg::OP_LOAD, sts_pkg::VAL_W'(3), 1'b0);
      add_cmd(sts_pkg::OP_LOAD, sts_pkg::VAL_W'(7), 1'b0);
      add_cmd(sts_pkg::OP_LOAD, sts_pkg::VAL_W'(3), 1'b1);
      add_cmd(sts_pkg::OP_SEARCH, sts_pkg::VAL_W'(3), 1'b0);
      add_cmd(sts_pkg::OP_SEARCH, sts_pkg::VAL_W'(5), 1'b0);
      // random runs, one overflowing the store
      while (cmd_queue.size() < 190) begin
         case ($urandom_range(0, 9))
            0:       n = $urandom_range(9, sts_pkg::DEPTH);
            default: n = $urandom_range(1, 8);
         endcase
         add_load_run(n);
         repeat ($urandom_range(1, 4))
            add_cmd(sts_pkg::OP_SEARCH, ($urandom_range(0, 2) != 0) ?
                    known_vals[$urandom_range(0, known_vals.size() - 1)] : rand_value(),
                    1'($urandom_range(0, 1)));
         if (!overflow_done && cmd_queue.size() > 80) begin
            overflow_done = 1'b1;
            add_load_run(sts_pkg::DEPTH + 6);
            add_cmd(sts_pkg::OP_SEARCH, known_vals[known_vals.size() - 10], 1'b0);
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (cmd_queue.size() != 0 || accepted != issued) @(posedge clock);
      while (answer_queue.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      if (answer_queue.size() != 0) mismatches = mismatches + answer_queue.size();
      $display("covered %0d transactions: %0d sorts, %0d searches, %0d responses",
               accepted, sorts_seen, searches_seen, responses);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0)
         $display("sort_then_binary_search test passed");
      else
         $display("sort_then_binary_search test failed");
      $finish;
   end
endmodule
`default_nettype wire
